### sv/encoder_motion_estimator_core_macros.svh
// Assertion macros shared by the motion estimator RTL.
`ifndef ENCODER_MOTION_ESTIMATOR_CORE_MACROS_SVH
`define ENCODER_MOTION_ESTIMATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define EME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define EME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/eme_pkg.sv
// Shared types and constants of the encoder motion estimator.
package eme_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int PERIOD_W       = 17;
  localparam int FRAC_BITS      = 16;
  localparam int INC_SHIFT      = 32 - FRAC_BITS;
  localparam int RATE_FRAC      = 16;
  localparam int DEG_SHIFT      = 26;
  localparam int A_W_MIN        = 33;
  localparam int A_W_DEF        = 33;
  localparam int CFG_ADDR_W     = 4;

  localparam logic [31:0] DEG_PER_RAD = 32'd3845054675;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd60000;
  localparam logic [31:0] RAD_RST  = 32'd2248840;
  localparam logic [31:0] MM_RST   = 32'd3937053;
  localparam logic [31:0] RATE_RST = 32'd65536000;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_PRESET = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_PERIOD = 2'd0,
    REG_RAD    = 2'd1,
    REG_MM     = 2'd2,
    REG_RATE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_INC_A = 3'd0,
    OP_INC_L = 3'd1,
    OP_VA    = 3'd2,
    OP_VL    = 3'd3,
    OP_DEG   = 3'd4,
    OP_AA    = 3'd5,
    OP_AL    = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    SH_INC  = 2'd0,
    SH_RATE = 2'd1,
    SH_DEG  = 2'd2
  } shsel_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_DELTA  = 4'd1,
    ST_INC_A  = 4'd2,
    ST_INC_L  = 4'd3,
    ST_GAP    = 4'd4,
    ST_VA     = 4'd5,
    ST_VL     = 4'd6,
    ST_DEG    = 4'd7,
    ST_AA     = 4'd8,
    ST_AL     = 4'd9,
    ST_DRAIN1 = 4'd10,
    ST_DRAIN2 = 4'd11,
    ST_DONE   = 4'd12
  } state_t;

  typedef struct packed {
    logic   valid;
    op_t    op;
    shsel_t shsel;
  } mul_ctl_t;

endpackage

### sv/eme_mul_unit.sv
// Shared three-stage signed-by-unsigned multiply with rounding shift and saturation.
module eme_mul_unit #(
  parameter int A_W = eme_pkg::A_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  eme_pkg::mul_ctl_t      issue_ctl,
  input  logic signed [A_W-1:0]  op_a,
  input  logic [31:0]            op_b,
  output eme_pkg::mul_ctl_t      res_ctl,
  output logic signed [31:0]     res_value
);

  localparam int HI_W = A_W - 32;
  localparam int P_W  = A_W + 32;

  localparam logic [P_W:0] RND_INC  = (P_W+1)'(1) << (eme_pkg::INC_SHIFT - 1);
  localparam logic [P_W:0] RND_RATE = (P_W+1)'(1) << (eme_pkg::RATE_FRAC - 1);
  localparam logic [P_W:0] RND_DEG  = (P_W+1)'(1) << (eme_pkg::DEG_SHIFT - 1);

  eme_pkg::mul_ctl_t ctl_a_r;
  eme_pkg::mul_ctl_t ctl_b_r;
  logic              neg_a_r;
  logic [A_W-1:0]    mag_a_r;
  logic [31:0]       b_a_r;
  logic              neg_b_r;
  logic [P_W-1:0]    prod_r;

  logic [A_W-1:0]    a_u;
  logic [A_W-1:0]    a_mag;
  logic [63:0]       pp_lo;
  logic [HI_W+31:0]  pp_hi;
  logic [P_W-1:0]    prod_nxt;
  logic [P_W:0]      shifted;
  logic              too_big;

  // Stage A: split the operand into sign and magnitude.
  assign a_u   = $unsigned(op_a);
  assign a_mag = op_a[A_W-1] ? (~a_u + A_W'(1)) : a_u;

  // Stage B: the low 32 bits of the magnitude take the one full-width multiplier;
  // the few upper bits form a narrow partial product.
  assign pp_lo    = mag_a_r[31:0] * b_a_r;
  assign pp_hi    = mag_a_r[A_W-1:32] * b_a_r;
  assign prod_nxt = P_W'(pp_lo) + {pp_hi, 32'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
      ctl_b_r.valid <= 1'b0;
    end else begin
      ctl_a_r <= issue_ctl;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    neg_a_r <= op_a[A_W-1];
    mag_a_r <= a_mag;
    b_a_r   <= op_b;
    neg_b_r <= neg_a_r;
    prod_r  <= prod_nxt;
  end

  // Stage C: round half away from zero on the magnitude, shift, then saturate.
  always_comb begin
    unique case (ctl_b_r.shsel)
      eme_pkg::SH_INC:  shifted = ({1'b0, prod_r} + RND_INC)  >> eme_pkg::INC_SHIFT;
      eme_pkg::SH_RATE: shifted = ({1'b0, prod_r} + RND_RATE) >> eme_pkg::RATE_FRAC;
      eme_pkg::SH_DEG:  shifted = ({1'b0, prod_r} + RND_DEG)  >> eme_pkg::DEG_SHIFT;
      default:          shifted = '0;
    endcase
    too_big = |shifted[P_W:31];
    if (neg_b_r) begin
      res_value = too_big ? eme_pkg::SAT_MIN : $signed(-shifted[31:0]);
    end else begin
      res_value = too_big ? eme_pkg::SAT_MAX : $signed(shifted[31:0]);
    end
  end

  assign res_ctl = ctl_b_r;

endmodule

### sv/encoder_motion_estimator_core.sv
// Encoder motion estimator: angle, travel, speeds and accelerations from counter samples.
//
// Input channel (in_valid/in_stall): one transfer per command. in_cmd selects a counter
// sample (in_raw_count) or a preset of the angular position (in_preset_value).
// Result channel (out_valid/out_stall): exactly one transfer per input transfer, carrying
// all seven signed Q16.16 values as they stand after that command.
// Configuration: APB-style port with read-back, registers at byte addresses 0, 4, 8 and 12
// (counter period, radians per count, millimetres per count, sample rate).
// For a counter sample after priming, the count difference is registered first; then
// seven multiplies run one after another through a single three-stage multiplier, with
// a bubble where a multiply needs the result of the one before, and the multiplier
// drains. A preset, or the first sample after reset, skips all of this. Every item
// loads the result register in its last step (ST_DONE).
// in_stall is low whenever the sequencer is idle, even while a result still waits in the
// output register; a finished item waits in its last step until that register is free.
// Reset clears all accumulators and history, loads the register defaults and leaves the
// block unprimed: the first sample only records the counter value.
`include "encoder_motion_estimator_core_macros.svh"

module encoder_motion_estimator_core #(
  parameter int COUNT_BITS = eme_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_cmd,
  input  logic [COUNT_BITS-1:0]          in_raw_count,
  input  logic signed [31:0]             in_preset_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_angle_rad,
  output logic signed [31:0]             out_angular_speed,
  output logic signed [31:0]             out_angular_accel,
  output logic signed [31:0]             out_angle_deg,
  output logic signed [31:0]             out_travel_mm,
  output logic signed [31:0]             out_linear_speed,
  output logic signed [31:0]             out_linear_accel,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [eme_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int DELTA_W = ((COUNT_BITS > eme_pkg::PERIOD_W) ? COUNT_BITS
                                                              : eme_pkg::PERIOD_W) + 2;
  localparam int A_W     = (DELTA_W > eme_pkg::A_W_MIN) ? DELTA_W : eme_pkg::A_W_MIN;

  // Configuration registers.
  logic [eme_pkg::PERIOD_W-1:0] period_r;
  logic [31:0]                  rad_r;
  logic [31:0]                  mm_r;
  logic [31:0]                  rate_r;

  // Estimator state.
  logic [COUNT_BITS-1:0] prev_count_r;
  logic                  primed_r;
  logic signed [31:0]    angle_r;
  logic signed [31:0]    prev_angle_r;
  logic signed [31:0]    ang_speed_r;
  logic signed [31:0]    ang_accel_r;
  logic signed [31:0]    deg_r;
  logic signed [31:0]    travel_r;
  logic signed [31:0]    prev_travel_r;
  logic signed [31:0]    lin_speed_r;
  logic signed [31:0]    lin_accel_r;

  // Per-item working registers.
  logic [COUNT_BITS-1:0]     raw_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [DELTA_W-1:0] delta_nxt;
  logic signed [31:0]        va_r;
  logic signed [31:0]        vl_r;

  // Result register.
  logic                out_valid_r;
  logic signed [31:0]  out_angle_rad_r;
  logic signed [31:0]  out_angular_speed_r;
  logic signed [31:0]  out_angular_accel_r;
  logic signed [31:0]  out_angle_deg_r;
  logic signed [31:0]  out_travel_mm_r;
  logic signed [31:0]  out_linear_speed_r;
  logic signed [31:0]  out_linear_accel_r;

  eme_pkg::state_t   state_r;
  eme_pkg::state_t   state_nxt;
  eme_pkg::mul_ctl_t issue_ctl;
  eme_pkg::mul_ctl_t res_ctl;
  eme_pkg::reg_idx_t reg_idx;

  logic                  in_accept;
  logic                  load_out;
  logic                  cfg_write;
  logic signed [A_W-1:0] op_a;
  logic [31:0]           op_b;
  logic signed [31:0]    res_value;
  logic signed [32:0]    ang_diff;
  logic signed [32:0]    trv_diff;
  logic signed [32:0]    va_diff;
  logic signed [32:0]    vl_diff;
  logic signed [DELTA_W-1:0] raw_diff;
  logic signed [DELTA_W-1:0] half_per;
  logic signed [DELTA_W-1:0] full_per;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'(x) + 33'(y);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? eme_pkg::SAT_MIN : eme_pkg::SAT_MAX;
    end else begin
      sat_add = $signed(s[31:0]);
    end
  endfunction

  assign in_stall  = (state_r != eme_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------- configuration
  assign pready    = 1'b1;
  assign reg_idx   = eme_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= eme_pkg::PERIOD_RST;
      rad_r    <= eme_pkg::RAD_RST;
      mm_r     <= eme_pkg::MM_RST;
      rate_r   <= eme_pkg::RATE_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        eme_pkg::REG_PERIOD: period_r <= pwdata[eme_pkg::PERIOD_W-1:0];
        eme_pkg::REG_RAD:    rad_r    <= pwdata;
        eme_pkg::REG_MM:     mm_r     <= pwdata;
        eme_pkg::REG_RATE:   rate_r   <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eme_pkg::REG_PERIOD: prdata = 32'(period_r);
      eme_pkg::REG_RAD:    prdata = rad_r;
      eme_pkg::REG_MM:     prdata = mm_r;
      eme_pkg::REG_RATE:   prdata = rate_r;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= eme_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    issue_ctl.valid = 1'b0;
    issue_ctl.op    = eme_pkg::OP_INC_A;
    issue_ctl.shsel = eme_pkg::SH_INC;
    load_out        = 1'b0;
    unique case (state_r)
      eme_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_cmd == eme_pkg::CMD_PRESET) || !primed_r) begin
            state_nxt = eme_pkg::ST_DONE;
          end else begin
            state_nxt = eme_pkg::ST_DELTA;
          end
        end
      end
      eme_pkg::ST_DELTA: state_nxt = eme_pkg::ST_INC_A;
      eme_pkg::ST_INC_A: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_INC_A, shsel: eme_pkg::SH_INC};
        state_nxt = eme_pkg::ST_INC_L;
      end
      eme_pkg::ST_INC_L: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_INC_L, shsel: eme_pkg::SH_INC};
        state_nxt = eme_pkg::ST_GAP;
      end
      // The new angle is written back at the end of this cycle.
      eme_pkg::ST_GAP: state_nxt = eme_pkg::ST_VA;
      eme_pkg::ST_VA: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_VA, shsel: eme_pkg::SH_RATE};
        state_nxt = eme_pkg::ST_VL;
      end
      eme_pkg::ST_VL: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_VL, shsel: eme_pkg::SH_RATE};
        state_nxt = eme_pkg::ST_DEG;
      end
      eme_pkg::ST_DEG: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_DEG, shsel: eme_pkg::SH_DEG};
        state_nxt = eme_pkg::ST_AA;
      end
      eme_pkg::ST_AA: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_AA, shsel: eme_pkg::SH_RATE};
        state_nxt = eme_pkg::ST_AL;
      end
      eme_pkg::ST_AL: begin
        issue_ctl = '{valid: 1'b1, op: eme_pkg::OP_AL, shsel: eme_pkg::SH_RATE};
        state_nxt = eme_pkg::ST_DRAIN1;
      end
      eme_pkg::ST_DRAIN1: state_nxt = eme_pkg::ST_DRAIN2;
      eme_pkg::ST_DRAIN2: state_nxt = eme_pkg::ST_DONE;
      eme_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = eme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = eme_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- count difference
  assign raw_diff = $signed(DELTA_W'(raw_r)) - $signed(DELTA_W'(prev_count_r));
  assign half_per = $signed(DELTA_W'(period_r >> 1));
  assign full_per = $signed(DELTA_W'(period_r));

  // The difference is folded by one period at most.
  always_comb begin
    priority if (raw_diff > half_per) begin
      delta_nxt = raw_diff - full_per;
    end else if (raw_diff < -half_per) begin
      delta_nxt = raw_diff + full_per;
    end else begin
      delta_nxt = raw_diff;
    end
  end

  // ---------------------------------------------------------------- multiplier operands
  assign ang_diff = 33'(angle_r) - 33'(prev_angle_r);
  assign trv_diff = 33'(travel_r) - 33'(prev_travel_r);
  assign va_diff  = 33'(va_r) - 33'(ang_speed_r);
  assign vl_diff  = 33'(vl_r) - 33'(lin_speed_r);

  always_comb begin
    unique case (issue_ctl.op)
      eme_pkg::OP_INC_A: begin op_a = A_W'(delta_r);  op_b = rad_r;                end
      eme_pkg::OP_INC_L: begin op_a = A_W'(delta_r);  op_b = mm_r;                 end
      eme_pkg::OP_VA:    begin op_a = A_W'(ang_diff); op_b = rate_r;               end
      eme_pkg::OP_VL:    begin op_a = A_W'(trv_diff); op_b = rate_r;               end
      eme_pkg::OP_DEG:   begin op_a = A_W'(angle_r);  op_b = eme_pkg::DEG_PER_RAD; end
      eme_pkg::OP_AA:    begin op_a = A_W'(va_diff);  op_b = rate_r;               end
      eme_pkg::OP_AL:    begin op_a = A_W'(vl_diff);  op_b = rate_r;               end
      default:           begin op_a = '0;             op_b = '0;                   end
    endcase
  end

  eme_mul_unit #(
    .A_W (A_W)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue_ctl (issue_ctl),
    .op_a      (op_a),
    .op_b      (op_b),
    .res_ctl   (res_ctl),
    .res_value (res_value)
  );

  // ---------------------------------------------------------------- state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_count_r  <= '0;
      primed_r      <= 1'b0;
      angle_r       <= '0;
      prev_angle_r  <= '0;
      ang_speed_r   <= '0;
      ang_accel_r   <= '0;
      deg_r         <= '0;
      travel_r      <= '0;
      prev_travel_r <= '0;
      lin_speed_r   <= '0;
      lin_accel_r   <= '0;
    end else begin
      if (in_accept) begin
        if (in_cmd == eme_pkg::CMD_PRESET) begin
          angle_r <= in_preset_value;
        end else if (!primed_r) begin
          prev_count_r <= in_raw_count;
          primed_r     <= 1'b1;
        end
      end
      if (state_r == eme_pkg::ST_DELTA) begin
        prev_count_r <= raw_r;
      end
      if (res_ctl.valid) begin
        unique case (res_ctl.op)
          eme_pkg::OP_INC_A: angle_r  <= sat_add(angle_r, res_value);
          eme_pkg::OP_INC_L: travel_r <= sat_add(travel_r, res_value);
          eme_pkg::OP_VA:    prev_angle_r  <= angle_r;
          eme_pkg::OP_VL:    prev_travel_r <= travel_r;
          eme_pkg::OP_DEG:   deg_r <= res_value;
          eme_pkg::OP_AA: begin
            ang_accel_r <= res_value;
            ang_speed_r <= va_r;
          end
          eme_pkg::OP_AL: begin
            lin_accel_r <= res_value;
            lin_speed_r <= vl_r;
          end
          default: ;
        endcase
      end
    end
  end

  // Working registers and the result payload need no reset.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      raw_r <= in_raw_count;
    end
    if (state_r == eme_pkg::ST_DELTA) begin
      delta_r <= delta_nxt;
    end
    if (res_ctl.valid && (res_ctl.op == eme_pkg::OP_VA)) begin
      va_r <= res_value;
    end
    if (res_ctl.valid && (res_ctl.op == eme_pkg::OP_VL)) begin
      vl_r <= res_value;
    end
    if (load_out) begin
      out_angle_rad_r     <= angle_r;
      out_angular_speed_r <= ang_speed_r;
      out_angular_accel_r <= ang_accel_r;
      out_angle_deg_r     <= deg_r;
      out_travel_mm_r     <= travel_r;
      out_linear_speed_r  <= lin_speed_r;
      out_linear_accel_r  <= lin_accel_r;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_angle_rad     = out_angle_rad_r;
  assign out_angular_speed = out_angular_speed_r;
  assign out_angular_accel = out_angular_accel_r;
  assign out_angle_deg     = out_angle_deg_r;
  assign out_travel_mm     = out_travel_mm_r;
  assign out_linear_speed  = out_linear_speed_r;
  assign out_linear_accel  = out_linear_accel_r;

  // ---------------------------------------------------------------- assertions
  `EME_ASSERT_IMP(a_res_while_busy, res_ctl.valid, (state_r != eme_pkg::ST_IDLE) && (state_r != eme_pkg::ST_DONE), "Multiplier result arrived outside the sample sequence.")
  `EME_ASSERT_NXT(a_preset_load, in_accept && (in_cmd == eme_pkg::CMD_PRESET), (angle_r == $past(in_preset_value)) && (state_r == eme_pkg::ST_DONE), "Preset did not load the angle.")
  `EME_ASSERT_NXT(a_primed_holds, primed_r, primed_r, "Block lost its primed flag outside reset.")
  `EME_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state_r == eme_pkg::ST_DONE), "Result became valid without a finished item.")

endmodule

### test/encoder_motion_estimator_core_test.sv
// Self-checking testbench for the encoder motion estimator core.
module encoder_motion_estimator_core_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE = 16;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int INC_SH = 16;
  localparam int RATE_SH = 16;
  localparam int DEG_SH = 26;
  localparam logic [31:0] DEG_SCALE = 32'd3845054675;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] angle_rad;
    logic signed [31:0] angular_speed;
    logic signed [31:0] angular_accel;
    logic signed [31:0] angle_deg;
    logic signed [31:0] travel_mm;
    logic signed [31:0] linear_speed;
    logic signed [31:0] linear_accel;
  } motion_t;

  // One command for the input channel; when known is set, want is the literal result.
  typedef struct packed {
    eme_pkg::cmd_t cmd;
    logic [15:0] raw;
    logic signed [31:0] preset;
    logic known;
    motion_t want;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  eme_pkg::cmd_t in_cmd = eme_pkg::CMD_SAMPLE;
  logic [15:0] in_raw_count = '0;
  logic signed [31:0] in_preset_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_angle_rad;
  logic signed [31:0] out_angular_speed;
  logic signed [31:0] out_angular_accel;
  logic signed [31:0] out_angle_deg;
  logic signed [31:0] out_travel_mm;
  logic signed [31:0] out_linear_speed;
  logic signed [31:0] out_linear_accel;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [eme_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  encoder_motion_estimator_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and register copies, as they stand after reset.
  logic [16:0] period_cfg = 17'd60000;
  logic [31:0] rad_cfg = 32'd2248840;
  logic [31:0] mm_cfg = 32'd3937053;
  logic [31:0] rate_cfg = 32'd65536000;
  logic prime_done = 1'b0;
  logic [15:0] last_count = '0;
  logic signed [31:0] ang_pos = '0, ang_pos_prev = '0, ang_speed = '0, ang_accel = '0;
  logic signed [31:0] ang_deg = '0;
  logic signed [31:0] lin_pos = '0, lin_pos_prev = '0, lin_speed = '0, lin_accel = '0;

  motion_t expected_motion[$];
  motion_t oldest;
  command_t directed[$];
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  bit gaps_on = 1'b1;
  logic [15:0] sent_raw = '0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  // Signed times unsigned, shifted right, rounded half away from zero, saturated.
  function automatic logic signed [31:0] scale_round_sat(input longint a, input logic [31:0] b,
                                                         input int sh);
    logic [63:0] mag;
    logic [127:0] prod;
    mag = (a < 0) ? -a : a;
    prod = ({64'd0, mag} * {96'd0, b} + (128'd1 << (sh - 1))) >> sh;
    if (a < 0) return (prod >= 128'h8000_0000) ? Q_MIN : -$signed(prod[31:0]);
    return (prod > 128'h7FFF_FFFF) ? Q_MAX : $signed(prod[31:0]);
  endfunction

  function automatic motion_t estimate_motion(input eme_pkg::cmd_t c, input logic [15:0] raw,
                                              input logic signed [31:0] pv);
    longint delta;
    longint half;
    logic signed [31:0] v;
    motion_t m;
    if (c == eme_pkg::CMD_PRESET) begin
      ang_pos = pv;
    end else if (!prime_done) begin
      last_count = raw;
      prime_done = 1'b1;
    end else begin
      delta = longint'(raw) - longint'(last_count);
      half = longint'(period_cfg >> 1);
      // The count difference is folded back at most once.
      if (delta > half) delta -= longint'(period_cfg);
      else if (delta < -half) delta += longint'(period_cfg);
      last_count = raw;

      ang_pos = clamp32(longint'(ang_pos) + longint'(scale_round_sat(delta, rad_cfg, INC_SH)));
      v = scale_round_sat(longint'(ang_pos) - longint'(ang_pos_prev), rate_cfg, RATE_SH);
      ang_accel = scale_round_sat(longint'(v) - longint'(ang_speed), rate_cfg, RATE_SH);
      ang_deg = scale_round_sat(longint'(ang_pos), DEG_SCALE, DEG_SH);
      ang_pos_prev = ang_pos;
      ang_speed = v;

      lin_pos = clamp32(longint'(lin_pos) + longint'(scale_round_sat(delta, mm_cfg, INC_SH)));
      v = scale_round_sat(longint'(lin_pos) - longint'(lin_pos_prev), rate_cfg, RATE_SH);
      lin_accel = scale_round_sat(longint'(v) - longint'(lin_speed), rate_cfg, RATE_SH);
      lin_pos_prev = lin_pos;
      lin_speed = v;
    end
    m.angle_rad = ang_pos;
    m.angular_speed = ang_speed;
    m.angular_accel = ang_accel;
    m.angle_deg = ang_deg;
    m.travel_mm = lin_pos;
    m.linear_speed = lin_speed;
    m.linear_accel = lin_accel;
    return m;
  endfunction

  function automatic command_t entry(input eme_pkg::cmd_t c, input logic [15:0] raw,
                                     input logic [31:0] pv, input logic known,
                                     input motion_t want);
    command_t r;
    r.cmd = c;
    r.raw = raw;
    r.preset = pv;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_command(input command_t r);
    motion_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_raw_count <= r.raw;
    in_preset_value <= r.preset;
    do @(posedge clk); while (in_stall);
    predicted = estimate_motion(r.cmd, r.raw, r.preset);
    expected_motion.push_back(r.known ? r.want : predicted);
    if (r.cmd == eme_pkg::CMD_SAMPLE) sent_raw = r.raw;
  endtask

  // Holds the sender back until every result is in and the block has gone quiet.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input eme_pkg::reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      eme_pkg::REG_PERIOD: period_cfg = val[16:0];
      eme_pkg::REG_RAD: rad_cfg = val;
      eme_pkg::REG_MM: mm_cfg = val;
      eme_pkg::REG_RATE: rate_cfg = val;
    endcase
  endtask

  task automatic configure(input int phase);
    logic [16:0] per;
    logic [31:0] rad;
    logic [31:0] mm;
    logic [31:0] rate;
    rad = $urandom >> $urandom_range(0, 12);
    mm = $urandom >> $urandom_range(0, 12);
    case (phase)
      0: begin per = 17'd65536; rad = '1; mm = '0; rate = 32'd65536; end
      1: begin per = 17'd2; rate = '0; end
      2: begin per = 17'd0; rate = 32'd65536000; end
      3: begin per = 17'd1; rate = 32'd6553600; end
      4: begin per = '1; rad = rad >> 4; mm = mm >> 4; rate = '1; end
      5: begin per = 17'd60000; rad = 32'd2248840; mm = 32'd3937053; rate = 32'd65536000; end
      default: begin
        per = 17'($urandom_range(2, 65536));
        rate = $urandom_range(0, 131072000);
      end
    endcase
    write_reg(eme_pkg::REG_PERIOD, 32'(per));
    write_reg(eme_pkg::REG_RAD, rad);
    write_reg(eme_pkg::REG_MM, mm);
    write_reg(eme_pkg::REG_RATE, rate);
  endtask

  task automatic random_phase(input int count);
    command_t r;
    logic [15:0] half;
    gaps_on = ($urandom_range(0, 3) != 0);
    repeat (count) begin
      r = '0;
      half = 16'(period_cfg >> 1);
      r.cmd = ($urandom_range(0, 99) < 7) ? eme_pkg::CMD_PRESET : eme_pkg::CMD_SAMPLE;
      r.preset = $urandom;
      if ($urandom_range(0, 1) == 1) r.preset = r.preset >>> 12;
      // Mostly small moves, with steps on either side of the fold threshold.
      case ($urandom_range(0, 9))
        0: r.raw = 16'($urandom);
        1: r.raw = sent_raw + half + 16'($urandom_range(0, 1));
        2: r.raw = sent_raw - half - 16'($urandom_range(0, 1));
        default: r.raw = sent_raw + 16'($urandom_range(0, 400)) - 16'd200;
      endcase
      send_command(r);
      if ($urandom_range(0, 199) == 0) wait_for_results();
    end
  endtask

  // Result side: checks each transfer and stalls on a pattern that changes now and then.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_motion.size() == 0) begin
        report_mismatch("result with nothing expected", out_angle_rad, '0);
      end else begin
        oldest = expected_motion.pop_front();
        check_field("angle_rad", out_angle_rad, oldest.angle_rad);
        check_field("angular_speed", out_angular_speed, oldest.angular_speed);
        check_field("angular_accel", out_angular_accel, oldest.angular_accel);
        check_field("angle_deg", out_angle_deg, oldest.angle_deg);
        check_field("travel_mm", out_travel_mm, oldest.travel_mm);
        check_field("linear_speed", out_linear_speed, oldest.linear_speed);
        check_field("linear_accel", out_linear_accel, oldest.linear_accel);
      end
      results_seen++;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 400);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= (stall_left % 8 < 4);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first sample only primes the counter; presets change the angle alone.
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h1234, 32'h0, 1'b1, '0));
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'h7FFF_FFFF, 1'b1,
                             {32'h7FFF_FFFF, 192'd0}));
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'hFFFF, 32'h8000_0000, 1'b1,
                             {32'h8000_0000, 192'd0}));
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'h0, 1'b1, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h1234, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h1235, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h1233, 32'h0, 1'b0, '0));
    // Steps of exactly half a period stay as they are; one more count folds.
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h8763, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'hFC94, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h8764, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h1233, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'hFFFF, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h0000, 32'h0, 1'b0, '0));
    // A preset shows up as speed at the following sample.
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'h0001_0000, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h0000, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'hFFFF_0000, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h0001, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h0001, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'h5555, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'hAAAA, 32'h0, 1'b0, '0));
    // Accumulator saturation at both ends.
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'h7FFF_FFFF, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'hAAAB, 32'h0, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_PRESET, 16'h0000, 32'h8000_0000, 1'b0, '0));
    directed.push_back(entry(eme_pkg::CMD_SAMPLE, 16'hAAAA, 32'h0, 1'b0, '0));
    foreach (directed[i]) send_command(directed[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      configure(phase);
      random_phase(PHASE_ITEMS);
    end
    wait_for_results();

    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
